// ----- sv/pci_pkg.sv -----
`timescale 1ns / 1ps
package pci_pkg;

	localparam int RGB_W       = 24;
	localparam int DIM_CFG_W   = 11;
	localparam int POS_W       = 10;
	localparam int CIDX_W      = 4;
	localparam int COUNT_W     = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 2;

	localparam int PALETTE_ENTRIES_DEF = 16;
	localparam int MAX_DIMENSION_DEF   = 1024;

	localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

endpackage

// ----- sv/pci_cell.sv -----
`timescale 1ns / 1ps
module pci_cell #(
	parameter int PALETTE_ENTRIES = pci_pkg::PALETTE_ENTRIES_DEF,
	parameter int IDX = 0
) (
	input  logic                                   clk,
	input  logic [pci_pkg::RGB_W-1:0]              pixel,
	input  logic [$clog2(PALETTE_ENTRIES+1)-1:0]   fill,
	input  logic                                   load,
	input  logic                                   hit_in,
	input  logic [$clog2(PALETTE_ENTRIES)-1:0]     idx_in,
	output logic                                   hit_out,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]     idx_out
);

	localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
	localparam int FILL_W = $clog2(PALETTE_ENTRIES+1);

	logic [pci_pkg::RGB_W-1:0] color_q;
	logic                      match;

	// entries are kept distinct, so at most one cell matches
	assign match   = (FILL_W'(IDX) < fill) && (color_q == pixel);
	assign hit_out = hit_in | match;
	assign idx_out = idx_in | (match ? IDX_W'(IDX) : '0);

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= pixel;
		end
	end

endmodule

// ----- sv/pci_pos.sv -----
`timescale 1ns / 1ps
module pci_pos #(
	parameter int MAX_DIMENSION = pci_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [pci_pkg::DIM_CFG_W-1:0]       width,
	input  logic [pci_pkg::DIM_CFG_W-1:0]       height,
	output logic [$clog2(MAX_DIMENSION)-1:0]    x,
	output logic [$clog2(MAX_DIMENSION)-1:0]    y,
	output logic                                last
);

	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam logic [31:0] MAXD = 32'(MAX_DIMENSION);

	logic [CNT_W-1:0] x_q, y_q;
	logic [31:0]      w32, h32, wl, hl;
	logic             x_end, y_end;

	// last column and row after clamping to 1..MAX_DIMENSION
	always_comb begin
		w32 = 32'(width);
		h32 = 32'(height);
		wl  = (w32 == 32'd0) ? 32'd0 : ((w32 > MAXD) ? MAXD - 32'd1 : w32 - 32'd1);
		hl  = (h32 == 32'd0) ? 32'd0 : ((h32 > MAXD) ? MAXD - 32'd1 : h32 - 32'd1);
	end

	assign x_end = 32'(x_q) >= wl;
	assign y_end = 32'(y_q) >= hl;
	assign x     = x_q;
	assign y     = y_q;
	assign last  = x_end & y_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (step) begin
			if (x_end) begin
				x_q <= '0;
				y_q <= y_end ? '0 : y_q + CNT_W'(1);
			end else begin
				x_q <= x_q + CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/palette_color_indexer_top.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                         payload
// s_axis    in   s_axis_tvalid / s_axis_tready     tdata = pixel_rgb
// m_axis    out  m_axis_tvalid / m_axis_tready     tdata, tuser, tlast
// cfg       in   cfg_we (no wait)                  cfg_index, cfg_data
//
// one item per clock while m_axis does not stall: the palette cells compare in
// parallel and pass the match down the chain, the result is registered on accept and shows in the next cycle.
// the output register frees in the cycle it is taken, so a stall on m_axis
// holds s_axis_tready low only while the result waits.
// reset empties the palette, zeroes the position and loads 640 x 480.
module palette_color_indexer_top #(
	parameter int PALETTE_ENTRIES = pci_pkg::PALETTE_ENTRIES_DEF,
	parameter int MAX_DIMENSION   = pci_pkg::MAX_DIMENSION_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pci_pkg::RGB_W-1:0]          s_axis_tdata,  // pixel_rgb
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// pixel_x, pixel_y, color_index, palette_count
	output logic [pci_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic [pci_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // write_enable, new_color
	output logic                               m_axis_tlast,  // end_of_image
	input  logic                               cfg_we,
	input  logic [pci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pci_pkg::DIM_CFG_W-1:0]      cfg_data
);

	localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
	localparam int FILL_W = $clog2(PALETTE_ENTRIES+1);
	localparam int CNT_W  = $clog2(MAX_DIMENSION);

	logic [pci_pkg::DIM_CFG_W-1:0] width_q, height_q;
	logic [FILL_W-1:0]             fill_q, fill_next;
	logic                          accept, room, added, hit, last;
	logic [IDX_W-1:0]              idx;
	logic [CNT_W-1:0]              x, y;
	logic                          hit_c [PALETTE_ENTRIES+1];
	logic [IDX_W-1:0]              idx_c [PALETTE_ENTRIES+1];
	logic [31:0]                   x32, y32, idx32, cnt32;

	logic                          out_valid_q;
	logic [pci_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic [pci_pkg::OUT_TUSER_W-1:0] out_user_q;
	logic                          out_last_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pci_pkg::WIDTH_RESET;
			height_q <= pci_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pci_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				pci_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hit_c[0] = 1'b0;
	assign idx_c[0] = '0;
	assign room     = fill_q < FILL_W'(PALETTE_ENTRIES);
	assign added    = !hit_c[PALETTE_ENTRIES] && room;

	genvar gi;
	generate
		for (gi = 0; gi < PALETTE_ENTRIES; gi++) begin : g_cell
			pci_cell #(
				.PALETTE_ENTRIES(PALETTE_ENTRIES),
				.IDX(gi)
			) u_cell (
				.clk(clk),
				.pixel(s_axis_tdata),
				.fill(fill_q),
				.load(accept && added && (fill_q == FILL_W'(gi))),
				.hit_in(hit_c[gi]),
				.idx_in(idx_c[gi]),
				.hit_out(hit_c[gi+1]),
				.idx_out(idx_c[gi+1])
			);
		end
	endgenerate

	pci_pos #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.width(width_q),
		.height(height_q),
		.x(x),
		.y(y),
		.last(last)
	);

	assign hit       = hit_c[PALETTE_ENTRIES] || added;
	assign idx       = added ? fill_q[IDX_W-1:0] : idx_c[PALETTE_ENTRIES];
	assign fill_next = fill_q + (added ? FILL_W'(1) : '0);

	assign x32   = 32'(x);
	assign y32   = 32'(y);
	assign idx32 = hit ? 32'(idx) : 32'd0;
	assign cnt32 = 32'(fill_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= last ? '0 : fill_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'b000,
				cnt32[pci_pkg::COUNT_W-1:0],
				idx32[pci_pkg::CIDX_W-1:0],
				y32[pci_pkg::POS_W-1:0],
				x32[pci_pkg::POS_W-1:0]};
			out_user_q <= {added, hit};
			out_last_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule
